@@ rtl/stall_detector_hysteresis_unit_defines.svh @@
// Assertion helpers for the stall detector.
// Every check is sampled on clk and is off while rst_n is low.
`ifndef STALL_DETECTOR_HYSTERESIS_UNIT_DEFINES_SVH
`define STALL_DETECTOR_HYSTERESIS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdh_pkg.sv @@
package sdh_pkg;

  // Window and field widths
  localparam int WINDOW_LEN = 100;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 26;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // Hysteresis compares: 10*sum against 9*N*thr and 11*N*thr
  localparam int SCALED_W   = SUM_W + 4;
  localparam int LO_MULT    = 9 * WINDOW_LEN;
  localparam int HI_MULT    = 11 * WINDOW_LEN;

  // Largest window sum that can occur
  localparam int SUM_MAX    = WINDOW_LEN * ((1 << SAMPLE_W) - 1);

endpackage

@@ rtl/stall_detector_hysteresis_unit.sv @@
// Stall detector: moving average of speed samples with a hysteresis threshold.
// Input channel (in_valid/in_ready) carries one speed sample per transfer.
// Output channel (out_valid/out_ready) returns one result per sample: the
// stuck flag, the active primitive (0 move, 1 wiggle), a pulse when the
// primitive changed, and the sum over the sample window.
// cfg_wr_en writes the stall threshold; write it only while the block is idle.
// A transferred sample is loaded into the input register, which also reads the
// old window entry; when the result register has room, the running sum and the
// flag are updated from it into the result register, which holds the result.
// Throughput: one sample per cycle while the receiver takes results; the window
// store has one read port and one write port; the running sum updates once per sample.
// Reset clears the window (per-entry valid bits, so old samples read as zero),
// the sum, the flag, the mode and the threshold; no clearing pass is needed.
// When the receiver stalls, the result holds and the input register still takes
// one more sample; in_ready drops only when both registers are occupied.
`include "stall_detector_hysteresis_unit_defines.svh"

module stall_detector_hysteresis_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sdh_pkg::SAMPLE_W-1:0] in_speed_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_stuck,
  output logic                         out_wiggle_mode,
  output logic                         out_mode_switched,
  output logic [sdh_pkg::SUM_W-1:0]    out_window_sum,
  input  logic                         cfg_wr_en,
  input  logic [sdh_pkg::SAMPLE_W-1:0] cfg_stall_threshold
);
  import sdh_pkg::*;

  // Window store and its bookkeeping
  logic [SAMPLE_W-1:0]   ring_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] ring_vld_r;
  logic [IDX_W-1:0]      head_idx_r;

  // Scaled thresholds
  logic [SCALED_W-1:0]   lo_thr_r;
  logic [SCALED_W-1:0]   hi_thr_r;

  // Input register: sample, its slot and the old entry of that slot
  logic                  s1_v_r;
  logic [SAMPLE_W-1:0]   s1_samp_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [SAMPLE_W-1:0]   s1_old_r;
  logic                  s1_old_vld_r;

  // Result register, also holds sum, flag and mode state
  logic                  out_v_r;
  logic                  stuck_r;
  logic                  mode_r;
  logic                  switched_r;
  logic [SUM_W-1:0]      sum_r;

  logic                  out_en, s1_en;
  logic                  in_fire, s1_fire;
  logic                  rd_bypass;
  logic [IDX_W-1:0]      head_idx_nxt;
  logic [SAMPLE_W-1:0]   old_sample;
  logic [SUM_W-1:0]      sum_nxt;
  logic [SCALED_W-1:0]   scaled_sum;
  logic                  stuck_nxt;

  // Handshake: each register moves when the one after it has room
  assign out_en   = !out_v_r || out_ready;
  assign s1_en    = !s1_v_r || out_en;
  assign in_ready = s1_en;
  assign in_fire  = in_valid && s1_en;
  assign s1_fire  = s1_v_r && out_en;

  // Slot pointer wraps after the last window entry
  assign head_idx_nxt = (head_idx_r == IDX_W'(WINDOW_LEN - 1)) ? '0 : head_idx_r + 1'b1;

  // Read of the slot being written in the same cycle takes the write data
  assign rd_bypass = s1_fire && (s1_idx_r == head_idx_r);

  // Running sum: drop the oldest sample, add the new one
  assign old_sample = s1_old_vld_r ? s1_old_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(s1_samp_r);

  // Hysteresis on 10*sum
  assign scaled_sum = (SCALED_W'(sum_nxt) << 3) + (SCALED_W'(sum_nxt) << 1);
  always_comb begin
    if (!stuck_r) begin
      stuck_nxt = (scaled_sum < lo_thr_r);
    end else begin
      stuck_nxt = !(scaled_sum > hi_thr_r);
    end
  end

  // Threshold register, kept as its two scaled products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_thr_r <= '0;
      hi_thr_r <= '0;
    end else if (cfg_wr_en) begin
      lo_thr_r <= SCALED_W'(cfg_stall_threshold) * SCALED_W'(LO_MULT);
      hi_thr_r <= SCALED_W'(cfg_stall_threshold) * SCALED_W'(HI_MULT);
    end
  end

  // Window store: write on input-register transfer, registered read on input transfer
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      ring_mem[s1_idx_r] <= s1_samp_r;
    end
    if (in_fire) begin
      s1_old_r <= rd_bypass ? s1_samp_r : ring_mem[head_idx_r];
    end
  end

  // Input register control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      head_idx_r   <= '0;
      ring_vld_r   <= '0;
      s1_old_vld_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        ring_vld_r[s1_idx_r] <= 1'b1;
      end
      if (in_fire) begin
        s1_v_r       <= 1'b1;
        head_idx_r   <= head_idx_nxt;
        s1_old_vld_r <= rd_bypass || ring_vld_r[head_idx_r];
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_samp_r <= in_speed_sample;
      s1_idx_r  <= head_idx_r;
    end
  end

  // Result register: running sum, flag, mode and switch pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      sum_r      <= '0;
      stuck_r    <= 1'b0;
      mode_r     <= 1'b0;
      switched_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        out_v_r    <= 1'b1;
        sum_r      <= sum_nxt;
        stuck_r    <= stuck_nxt;
        mode_r     <= stuck_nxt;
        switched_r <= (stuck_nxt != mode_r);
      end else if (out_en) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_stuck         = stuck_r;
  assign out_wiggle_mode   = mode_r;
  assign out_mode_switched = switched_r;
  assign out_window_sum    = sum_r;

  // Checks
  `SDH_ASSERT_NOW(a_mode_follows_flag, 1'b1, mode_r == stuck_r, "mode differs from flag")
  `SDH_ASSERT_NOW(a_sum_in_range, 1'b1, sum_r <= SUM_W'(SUM_MAX), "window sum out of range")
  `SDH_ASSERT_NOW(a_idx_in_range, 1'b1, head_idx_r <= IDX_W'(WINDOW_LEN - 1), "slot past window")
  `SDH_ASSERT_NOW(a_full_when_blocked, !in_ready, s1_v_r && out_v_r, "blocked with a bubble")
  `SDH_ASSERT_NEXT(a_sum_holds_idle, !s1_fire, sum_r == $past(sum_r), "sum moved without a sample")

endmodule
